### rtl/zhang_suen_thinning_pass_unit_macros.svh
// Assertion macros for the thinning pass unit.
// Included by the top level; the macros expect clk and arst_n in scope.
`ifndef ZHANG_SUEN_THINNING_PASS_UNIT_MACROS_SVH
`define ZHANG_SUEN_THINNING_PASS_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ZS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ZS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/zs_pkg.sv
// Shared types and constants of the thinning pass unit.
// No dependencies; imported by every module of the block.
package zs_pkg;

	localparam int ZS_MAX_WIDTH   = 1024;
	localparam int ZS_QUEUE_DEPTH = 4;

	localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_ODD_PASS     = 2'd2;

	localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd640;
	localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd480;
	localparam logic        RST_ODD_PASS     = 1'b1;

	typedef struct packed {
		logic [10:0] image_width;
		logic [15:0] image_height;
		logic        odd_pass;
	} zs_cfg_t;

	typedef struct packed {
		logic        has_int;
		logic        has_bdr;
		logic [7:0]  int_px;
		logic        int_rem;
		logic [7:0]  bdr_px;
		logic [15:0] row;
		logic [9:0]  col;
		logic        eof;
	} zs_entry_t;

	typedef struct packed {
		logic full;
		logic avail;
	} zs_qstat_t;

endpackage

### rtl/zs_front.sv
// Front end: input counters, line store, 3x3 window and thinning decision.
// Depends on zs_pkg; feeds classified entries to zs_queue.
module zs_front #(
	parameter int MAX_WIDTH = zs_pkg::ZS_MAX_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  zs_pkg::zs_cfg_t    cfg,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // pixel_in[7:0]
	input  zs_pkg::zs_qstat_t  qstat,
	output logic               q_push,
	output zs_pkg::zs_entry_t  q_entry
);
	import zs_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = $clog2(MAX_WIDTH + 1);

	logic [CW-1:0] col_q;
	logic [15:0]   row_q;
	logic [EW-1:0] eff_w;
	logic [15:0]   eff_h;
	logic          accept;
	logic          wrap_in;
	logic [CW-1:0] c0;
	logic [15:0]   r_pre;
	logic [15:0]   r0;
	logic          row_end;
	logic [16:0]   r0_inc;

	logic          v_s1;
	logic [7:0]    px_s1;
	logic [15:0]   rd_s1;
	logic [CW-1:0] c_s1;
	logic [15:0]   r_s1;
	logic          int_s1;
	logic          bdr_s1;
	logic          eof_s1;
	logic          need_push;
	logic          fire_s1;

	logic [15:0]   line_mem [MAX_WIDTH];
	logic [23:0]   win_a_q;
	logic [23:0]   win_b_q;
	logic [23:0]   new_col;
	logic [7:0]    centre;
	logic [7:0]    ring;
	logic [3:0]    trans_n;
	logic [3:0]    set_n;
	logic          t1;
	logic          t2;
	logic          rem;

	always_comb begin
		if (cfg.image_width < 11'd3) begin
			eff_w = EW'(3);
		end else if (32'(cfg.image_width) > MAX_WIDTH) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = EW'(cfg.image_width);
		end
		eff_h = (cfg.image_height < 16'd3) ? 16'd3 : cfg.image_height;
	end

	assign accept  = s_tvalid && s_tready;
	assign wrap_in = 32'(col_q) >= 32'(eff_w);
	assign c0      = wrap_in ? '0 : col_q;
	assign r_pre   = wrap_in ? row_q + 16'd1 : row_q;
	assign r0      = (r_pre >= eff_h) ? 16'd0 : r_pre;
	assign row_end = (32'(c0) + 32'd1) >= 32'(eff_w);
	assign r0_inc  = {1'b0, r0} + 17'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= (r0_inc >= {1'b0, eff_h}) ? 16'd0 : r0_inc[15:0];
			end else begin
				col_q <= c0 + CW'(1);
				row_q <= r0;
			end
		end
	end

	assign need_push = int_s1 || bdr_s1;
	assign fire_s1   = v_s1 && (!need_push || !qstat.full);
	assign s_tready  = !v_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (fire_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1  <= line_mem[c0];
			px_s1  <= s_tdata;
			c_s1   <= c0;
			r_s1   <= r0;
			int_s1 <= (r0 >= 16'd2) && (32'(c0) >= 32'd2);
			bdr_s1 <= (r0 == 16'd0) || (r0 == eff_h - 16'd1) || (c0 == '0)
				|| (32'(c0) == 32'(eff_w) - 32'd1);
			eof_s1 <= (r0 == eff_h - 16'd1) && (32'(c0) == 32'(eff_w) - 32'd1);
		end
		if (fire_s1) begin
			line_mem[c_s1] <= {rd_s1[7:0], px_s1};
		end
	end

	// Each line store entry holds the pixel two rows up above the one a row up.
	assign new_col = {rd_s1, px_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_a_q <= '0;
			win_b_q <= '0;
		end else if (fire_s1) begin
			win_a_q <= win_b_q;
			win_b_q <= new_col;
		end
	end

	always_comb begin
		centre  = win_b_q[15:8];
		ring[0] = win_b_q[23:16] != 8'd0;
		ring[1] = new_col[23:16] != 8'd0;
		ring[2] = new_col[15:8]  != 8'd0;
		ring[3] = new_col[7:0]   != 8'd0;
		ring[4] = win_b_q[7:0]   != 8'd0;
		ring[5] = win_a_q[7:0]   != 8'd0;
		ring[6] = win_a_q[15:8]  != 8'd0;
		ring[7] = win_a_q[23:16] != 8'd0;
		trans_n = 4'd0;
		set_n   = 4'd0;
		for (int i = 0; i < 8; i++) begin
			trans_n = trans_n + 4'((!ring[i] && ring[(i + 1) % 8]) ? 1 : 0);
			set_n   = set_n + 4'(ring[i] ? 1 : 0);
		end
		if (cfg.odd_pass) begin
			t1 = ring[0] && ring[2] && ring[4];
			t2 = ring[2] && ring[4] && ring[6];
		end else begin
			t1 = ring[0] && ring[2] && ring[6];
			t2 = ring[0] && ring[4] && ring[6];
		end
		rem = (centre != 8'd0) && (trans_n == 4'd1) && (set_n >= 4'd2)
			&& (set_n < 4'd7) && !t1 && !t2;
	end

	always_comb begin
		q_entry.has_int = int_s1;
		q_entry.has_bdr = bdr_s1;
		q_entry.int_px  = rem ? 8'd0 : centre;
		q_entry.int_rem = rem;
		q_entry.bdr_px  = px_s1;
		q_entry.row     = r_s1;
		q_entry.col     = 10'(c_s1);
		q_entry.eof     = eof_s1;
	end

	assign q_push = fire_s1 && need_push;

endmodule

### rtl/zs_queue.sv
// Short entry queue between the front end and the result sequencer.
// Depends on zs_pkg for the entry and status types.
module zs_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  zs_pkg::zs_entry_t  wdata,
	input  logic               pop,
	output zs_pkg::zs_entry_t  rdata,
	output zs_pkg::zs_qstat_t  qstat
);
	import zs_pkg::*;

	localparam int AW = (ZS_QUEUE_DEPTH > 1) ? $clog2(ZS_QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(ZS_QUEUE_DEPTH + 1);

	zs_entry_t     slot_q [ZS_QUEUE_DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [NW-1:0] count_q;

	assign qstat.full  = count_q == NW'(ZS_QUEUE_DEPTH);
	assign qstat.avail = count_q != '0;
	assign rdata       = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (32'(wptr_q) == ZS_QUEUE_DEPTH - 1) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (32'(rptr_q) == ZS_QUEUE_DEPTH - 1) ? '0 : rptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wdata;
		end
	end

endmodule

### rtl/zs_back.sv
// Result sequencer: expands each queue entry into one or two result transfers.
// Depends on zs_pkg; drives the registered output stream.
module zs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  zs_pkg::zs_qstat_t  qstat,
	input  zs_pkg::zs_entry_t  head,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [39:0]        m_tdata,   // pixel_out[7:0], out_row[15:0], out_column[9:0],
	                                      // removed, zero fill
	output logic               m_tlast,   // last_of_run
	output logic               m_tuser    // end_of_frame
);
	import zs_pkg::*;

	logic second_q;
	logic load;
	logic int_now;

	assign load    = qstat.avail && (!m_tvalid || m_tready);
	assign int_now = head.has_int && !second_q;
	assign pop     = load && !(int_now && head.has_bdr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (load) begin
				m_tvalid <= 1'b1;
				second_q <= int_now && head.has_bdr;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (int_now) begin
				m_tdata <= {5'd0, head.int_rem, head.col - 10'd1, head.row - 16'd1,
					head.int_px};
				m_tlast <= !head.has_bdr;
				m_tuser <= 1'b0;
			end else begin
				m_tdata <= {5'd0, 1'b0, head.col, head.row, head.bdr_px};
				m_tlast <= 1'b1;
				m_tuser <= head.eof;
			end
		end
	end

endmodule

### rtl/zhang_suen_thinning_pass_unit.sv
// Channel   Direction  Payload
// cfg       in         cfg_index selects register, cfg_data value, written on cfg_we
// s         in         s_tdata: pixel_in, raster order
// m         out        m_tdata: pixel_out, out_row, out_column, removed; tlast, tuser
//
// One pixel is accepted per clock while the queue has room: the line store has one read
// and one write port and the window logic is one stage. The sequencer sends one result
// per cycle while m_tready is high; the queue absorbs the second result of a two-result
// pixel inside a frame, but on the last row, where most pixels yield two results, input
// slows to the sequencer's pace. Output stalls back up through the queue to s_tready.
// Reset clears counters, the window and valid flags; line store contents start undefined.
`include "zhang_suen_thinning_pass_unit_macros.svh"

module zhang_suen_thinning_pass_unit #(
	parameter int MAX_WIDTH = zs_pkg::ZS_MAX_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // pixel_in[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // pixel_out[7:0], out_row[15:0], out_column[9:0],
	                               // removed, zero fill
	output logic        m_tlast,   // last_of_run
	output logic        m_tuser    // end_of_frame
);
	import zs_pkg::*;

	zs_cfg_t   cfg_q;
	zs_qstat_t qstat;
	zs_entry_t push_entry;
	zs_entry_t head_entry;
	logic      q_push;
	logic      q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= RST_IMAGE_WIDTH;
			cfg_q.image_height <= RST_IMAGE_HEIGHT;
			cfg_q.odd_pass     <= RST_ODD_PASS;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH: begin
					cfg_q.image_width <= cfg_data[10:0];
				end
				CFG_IMAGE_HEIGHT: begin
					cfg_q.image_height <= cfg_data;
				end
				CFG_ODD_PASS: begin
					cfg_q.odd_pass <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	zs_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.qstat    (qstat),
		.q_push   (q_push),
		.q_entry  (push_entry)
	);

	zs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (push_entry),
		.pop    (q_pop),
		.rdata  (head_entry),
		.qstat  (qstat)
	);

	zs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.head     (head_entry),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	`ZS_ASSERT_IMP(a_eof_is_last, m_tvalid && m_tuser, m_tlast, "end of frame without last flag")
	`ZS_ASSERT_IMP(a_removed_zero, m_tvalid && m_tdata[34], m_tdata[7:0] == 8'd0, "removed pixel not zero")
	`ZS_ASSERT_IMP(a_push_room, q_push, !qstat.full, "queue push while full")
	`ZS_ASSERT_NXT(a_push_visible, q_push && !q_pop, qstat.avail, "pushed entry not visible")

endmodule

### tb/zhang_suen_thinning_pass_unit_tb.sv
// Self-checking testbench for the Zhang-Suen thinning pass unit.
// Predicts every result from the accepted pixel stream and checks it against the
// master-side output; depends on zs_pkg and the zhang_suen_thinning_pass_unit RTL.
module zhang_suen_thinning_pass_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import zs_pkg::*;

	localparam int RANDOM_ITEMS   = 650;
	localparam int DIRECTED_ITEMS = 18;
	localparam int SETTLE_CYCLES  = 16;

	typedef struct packed {
		logic [7:0]  pixel;
		logic [15:0] row;
		logic [9:0]  col;
		logic        removed;
		logic        last;
		logic        eof;
	} pixel_result_t;

	class thinning_checker;
		int unsigned   width_reg;
		int unsigned   height_reg;
		bit            odd_reg;
		logic [7:0]    upper_row [ZS_MAX_WIDTH];
		logic [7:0]    middle_row [ZS_MAX_WIDTH];
		logic [23:0]   column_win [3];
		int unsigned   col_pos;
		int unsigned   row_pos;
		pixel_result_t expected_q [$];
		int            errors;
		int            reported;

		function new();
			width_reg = RST_IMAGE_WIDTH;
			height_reg = RST_IMAGE_HEIGHT;
			odd_reg = RST_ODD_PASS;
			foreach (upper_row[i]) begin
				upper_row[i] = '0;
				middle_row[i] = '0;
			end
			foreach (column_win[i]) column_win[i] = '0;
			col_pos = 0;
			row_pos = 0;
			errors = 0;
			reported = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				CFG_IMAGE_WIDTH: width_reg = val[10:0];
				CFG_IMAGE_HEIGHT: height_reg = val;
				CFG_ODD_PASS: odd_reg = val[0];
				default: ;
			endcase
		endfunction

		function int unsigned eff_width();
			if (width_reg < 3) return 3;
			if (width_reg > ZS_MAX_WIDTH) return ZS_MAX_WIDTH;
			return width_reg;
		endfunction

		function int unsigned eff_height();
			return (height_reg < 3) ? 3 : height_reg;
		endfunction

		function bit clears_center();
			bit p2, p3, p4, p5, p6, p7, p8, p9;
			bit ring [9];
			int trans;
			int cnt;
			bit t1, t2;
			p2 = column_win[1][23:16] != 0;
			p3 = column_win[2][23:16] != 0;
			p4 = column_win[2][15:8] != 0;
			p5 = column_win[2][7:0] != 0;
			p6 = column_win[1][7:0] != 0;
			p7 = column_win[0][7:0] != 0;
			p8 = column_win[0][15:8] != 0;
			p9 = column_win[0][23:16] != 0;
			ring = '{p2, p3, p4, p5, p6, p7, p8, p9, p2};
			trans = 0;
			cnt = 0;
			for (int i = 0; i < 8; i++) begin
				if (!ring[i] && ring[i + 1]) trans++;
				if (ring[i]) cnt++;
			end
			if (trans != 1 || cnt < 2 || cnt > 6) return 0;
			if (odd_reg) begin
				t1 = p2 && p4 && p6;
				t2 = p4 && p6 && p8;
			end else begin
				t1 = p2 && p4 && p8;
				t2 = p2 && p6 && p8;
			end
			return !t1 && !t2;
		endfunction

		function void note_pixel(logic [7:0] px);
			int unsigned   w, h, r, c;
			logic [7:0]    up, mid, center;
			pixel_result_t res [2];
			int            n;
			bit            rem;
			w = eff_width();
			h = eff_height();
			n = 0;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
			end
			if (row_pos >= h) row_pos = 0;
			r = row_pos;
			c = col_pos;
			up = upper_row[c];
			mid = middle_row[c];
			upper_row[c] = mid;
			middle_row[c] = px;
			column_win[0] = column_win[1];
			column_win[1] = column_win[2];
			column_win[2] = {up, mid, px};
			if (r >= 2 && c >= 2) begin
				center = column_win[1][15:8];
				rem = (center != 0) ? clears_center() : 1'b0;
				res[n] = '{pixel: rem ? 8'd0 : center, row: 16'(r - 1), col: 10'(c - 1),
					removed: rem, last: 1'b0, eof: 1'b0};
				n++;
			end
			if (r == 0 || r == h - 1 || c == 0 || c == w - 1) begin
				res[n] = '{pixel: px, row: 16'(r), col: 10'(c), removed: 1'b0, last: 1'b0,
					eof: (r == h - 1 && c == w - 1)};
				n++;
			end
			if (n > 0) res[n - 1].last = 1'b1;
			for (int i = 0; i < n; i++) expected_q.push_back(res[i]);
			if (c + 1 >= w) begin
				col_pos = 0;
				row_pos = (r + 1 >= h) ? 0 : r + 1;
			end else begin
				col_pos = c + 1;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void check_result(logic [39:0] data, logic tlast, logic tuser);
			pixel_result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("tb: unexpected result data %h last %b user %b", data, tlast, tuser);
				end
				return;
			end
			want = expected_q.pop_front();
			if (data[7:0] !== want.pixel || data[23:8] !== want.row
					|| data[33:24] !== want.col || data[34] !== want.removed
					|| data[39:35] !== 5'd0 || tlast !== want.last || tuser !== want.eof) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("tb: mismatch expected px %0d row %0d col %0d rem %0d last %0d eof %0d",
						want.pixel, want.row, want.col, want.removed, want.last, want.eof);
					$display("tb:          actual   px %0d row %0d col %0d rem %0d last %0d eof %0d fill %h",
						data[7:0], data[23:8], data[33:24], data[34], tlast, tuser, data[39:35]);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	thinning_checker sb = new();
	int              sent = 0;

	zhang_suen_thinning_pass_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Entered and left at a falling edge; valid stays high when no gap follows.
	task automatic send_pixel(input logic [7:0] px, input bit burst);
		int gap;
		int pick;
		pick = $urandom_range(0, 99);
		if (burst || pick < 70) gap = 0;
		else if (pick < 95) gap = $urandom_range(1, 3);
		else gap = $urandom_range(8, 40);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		do @(posedge clk); while (!s_tready);
		sb.note_pixel(px);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain_block();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic configure(input logic [10:0] w, input logic [15:0] h, input logic odd);
		cfg_we <= 1'b1;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data <= {5'd0, w};
		sb.set_reg(CFG_IMAGE_WIDTH, {5'd0, w});
		@(negedge clk);
		cfg_index <= CFG_IMAGE_HEIGHT;
		cfg_data <= h;
		sb.set_reg(CFG_IMAGE_HEIGHT, h);
		@(negedge clk);
		cfg_index <= CFG_ODD_PASS;
		cfg_data <= {15'd0, odd};
		sb.set_reg(CFG_ODD_PASS, {15'd0, odd});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int stall;
		int run;
		int pick;
		stall = 0;
		run = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall == 0 && run == 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 15) stall = $urandom_range(1, 3);
				else if (pick < 18) stall = $urandom_range(15, 50);
				else if (pick < 25) run = $urandom_range(50, 200);
				else run = $urandom_range(1, 4);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
				run--;
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid === 1'b1 && m_tready)
				sb.check_result(m_tdata, m_tlast, m_tuser);
		end
	end

	initial begin
		#40_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [7:0]  frame_odd [9];
		logic [7:0]  frame_even [9];
		int unsigned nw, nh, ew, eh, pr, pc, remaining, count, density;
		int          phase, pick;
		bit          nodd, burst, at_start;
		logic [7:0]  px;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_IMAGE_WIDTH;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		// Center cleared by the first sub-iteration, then by the second.
		frame_odd = '{8'd255, 8'd128, 8'd0, 8'd1, 8'd77, 8'd0, 8'd0, 8'd0, 8'd0};
		frame_even = '{8'd0, 8'd0, 8'd0, 8'd9, 8'd200, 8'd3, 8'd255, 8'd64, 8'd17};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		configure(11'd3, 16'd3, 1'b1);
		foreach (frame_odd[i]) send_pixel(frame_odd[i], 1'b0);
		drain_block();
		// Width and height below the minimum are raised to three.
		configure(11'd0, 16'd2, 1'b0);
		foreach (frame_even[i]) send_pixel(frame_even[i], 1'b0);

		phase = 0;
		while (sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			drain_block();
			at_start = (sb.row_pos == 0 && sb.col_pos == 0);
			pick = $urandom_range(0, 99);
			if (pick < 70) nw = $urandom_range(3, 8);
			else if (pick < 80) nw = $urandom_range(0, 2);
			else if (pick < 95) nw = $urandom_range(9, 40);
			else nw = $urandom_range(1025, 2047);
			pick = $urandom_range(0, 99);
			if (phase == 1) nh = 65535;
			else if (pick < 70) nh = $urandom_range(3, 6);
			else if (pick < 85) nh = $urandom_range(0, 2);
			else if (pick < 95) nh = $urandom_range(7, 12);
			else nh = $urandom_range(13, 65535);
			// Inside a frame the width may only shrink, so no unwritten line entry is read.
			ew = (nw < 3) ? 3 : ((nw > ZS_MAX_WIDTH) ? ZS_MAX_WIDTH : nw);
			if (!at_start && ew > sb.eff_width()) nw = sb.width_reg;
			nodd = $urandom_range(0, 1);
			configure(11'(nw), 16'(nh), nodd);

			ew = sb.eff_width();
			eh = sb.eff_height();
			pc = sb.col_pos;
			pr = sb.row_pos;
			if (pc >= ew) begin
				pc = 0;
				pr++;
			end
			if (pr >= eh) pr = 0;
			remaining = (eh - pr) * ew - pc;
			if (remaining <= 120 && $urandom_range(0, 3) != 0) count = remaining;
			else count = $urandom_range(1, 40);

			density = $urandom_range(10, 90);
			burst = ($urandom_range(0, 3) == 0);
			repeat (count) begin
				pick = $urandom_range(0, 99);
				if (pick >= density) px = 8'd0;
				else if (pick < density / 5) px = 8'd255;
				else if (pick < density / 5 + density / 10) px = 8'd1;
				else px = 8'($urandom_range(1, 255));
				send_pixel(px, burst);
			end
			phase++;
		end

		drain_block();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
